// File: hw/rtl/uvst_pkg.sv
// ----------------------------------------------------------------------------
// uvst_pkg
// Shared types, widths, grid constants and the build-time sine and cosine
// tables of the UV sphere tessellator.
// ----------------------------------------------------------------------------
package uvst_pkg;

  // grid size
  localparam int unsigned SECTORS = 50;
  localparam int unsigned STACKS  = 50;
  localparam int unsigned COLS    = SECTORS + 1;

  // folding bounds of the angle reduction
  localparam int unsigned STK2 = 2 * STACKS;
  localparam int unsigned STK4 = 4 * STACKS;
  localparam int unsigned SEC2 = 2 * SECTORS;
  localparam int unsigned SEC4 = 4 * SECTORS;

  // field widths
  localparam int unsigned IDX_W      = 7;
  localparam int unsigned POS_W      = 17;
  localparam int unsigned NORM_W     = 16;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned RADIUS_W   = 16;
  localparam int unsigned CORNER_W   = 13;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 24;

  // table index widths
  localparam int unsigned STK_IW = $clog2(STACKS + 1);
  localparam int unsigned SEC_IW = $clog2(SECTORS + 1);

  // register reset values
  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(256);
  localparam logic [COLOR_W-1:0]  COLOR_RST  = {COLOR_W{1'b1}};

  // pi in Q2.30
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // request and record kinds
  typedef enum logic {
    FUNC_VERTEX   = 1'b0,
    FUNC_TRIANGLE = 1'b1
  } func_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 1'b0,
    CFG_COLOR  = 1'b1
  } cfg_reg_e;

  typedef logic signed [NORM_W-1:0] stk_tbl_t [STACKS+1];
  typedef logic signed [NORM_W-1:0] sec_tbl_t [SECTORS+1];

  // taylor series of sin in Q2.30 on a folded angle, rounded to Q1.14
  function automatic logic signed [NORM_W-1:0] q14_sin(input logic [63:0] x,
                                                       input logic neg);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        r;
    int                 n;
    x2   = (x * x) >> 30;
    term = x;
    acc  = 64'sd0;
    for (n = 1; n <= 17; n += 2) begin
      if (((n >> 1) & 1) == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
      term = ((term * x2) >> 30) / 64'((n + 1) * (n + 2));
    end
    if (acc < 64'sd0) acc = 64'sd0;
    if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
    r = (64'(acc) + 64'd32768) >> 16;
    return neg ? -NORM_W'(r) : NORM_W'(r);
  endfunction

  // sin(pi*k/STACKS)
  function automatic logic signed [NORM_W-1:0] sin_stk(input int unsigned k0);
    int unsigned k;
    logic        neg;
    k   = k0 % STK2;
    neg = 1'b0;
    if (k >= STACKS) begin
      k   = k - STACKS;
      neg = 1'b1;
    end
    if (2 * k > STACKS) k = STACKS - k;
    return q14_sin((PI_Q30 * 64'(k)) / STACKS, neg);
  endfunction

  // sin(pi*k/(2*STACKS))
  function automatic logic signed [NORM_W-1:0] sin_stk2(input int unsigned k0);
    int unsigned k;
    logic        neg;
    k   = k0 % STK4;
    neg = 1'b0;
    if (k >= STK2) begin
      k   = k - STK2;
      neg = 1'b1;
    end
    if (2 * k > STK2) k = STK2 - k;
    return q14_sin((PI_Q30 * 64'(k)) / STK2, neg);
  endfunction

  // sin(pi*k/SECTORS)
  function automatic logic signed [NORM_W-1:0] sin_sec(input int unsigned k0);
    int unsigned k;
    logic        neg;
    k   = k0 % SEC2;
    neg = 1'b0;
    if (k >= SECTORS) begin
      k   = k - SECTORS;
      neg = 1'b1;
    end
    if (2 * k > SECTORS) k = SECTORS - k;
    return q14_sin((PI_Q30 * 64'(k)) / SECTORS, neg);
  endfunction

  // sin(pi*k/(2*SECTORS))
  function automatic logic signed [NORM_W-1:0] sin_sec2(input int unsigned k0);
    int unsigned k;
    logic        neg;
    k   = k0 % SEC4;
    neg = 1'b0;
    if (k >= SEC2) begin
      k   = k - SEC2;
      neg = 1'b1;
    end
    if (2 * k > SEC2) k = SEC2 - k;
    return q14_sin((PI_Q30 * 64'(k)) / SEC2, neg);
  endfunction

  // ring radius factor per band
  function automatic stk_tbl_t build_ring();
    stk_tbl_t t;
    for (int i = 0; i <= STACKS; i++) t[i] = sin_stk(i);
    return t;
  endfunction

  // height factor per band
  function automatic stk_tbl_t build_zc();
    stk_tbl_t t;
    for (int i = 0; i <= STACKS; i++) t[i] = sin_stk2(2 * i + STACKS);
    return t;
  endfunction

  // cosine of the sector angle
  function automatic sec_tbl_t build_cs();
    sec_tbl_t t;
    for (int j = 0; j <= SECTORS; j++) t[j] = sin_sec2(4 * j + SECTORS);
    return t;
  endfunction

  // sine of the sector angle
  function automatic sec_tbl_t build_sn();
    sec_tbl_t t;
    for (int j = 0; j <= SECTORS; j++) t[j] = sin_sec(2 * j);
    return t;
  endfunction

  localparam stk_tbl_t RING_TBL = build_ring();
  localparam stk_tbl_t ZC_TBL   = build_zc();
  localparam sec_tbl_t CS_TBL   = build_cs();
  localparam sec_tbl_t SN_TBL   = build_sn();

endpackage

// File: hw/rtl/uvst_req_if.sv
// ----------------------------------------------------------------------------
// uvst_req_if
// Request channel of the tessellator: one grid point and request kind per beat.
// ----------------------------------------------------------------------------
interface uvst_req_if ();

  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [uvst_pkg::IDX_W-1:0]  stack_index;
  logic [uvst_pkg::IDX_W-1:0]  sector_index;

  modport source (
    output valid, func, stack_index, sector_index,
    input  ready
  );

  modport sink (
    input  valid, func, stack_index, sector_index,
    output ready
  );

endinterface

// File: hw/rtl/uvst_rsp_if.sv
// ----------------------------------------------------------------------------
// uvst_rsp_if
// Result channel of the tessellator: one vertex or triangle record per beat.
// ----------------------------------------------------------------------------
interface uvst_rsp_if ();

  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [uvst_pkg::POS_W-1:0]   pos_x;
  logic signed [uvst_pkg::POS_W-1:0]   pos_y;
  logic signed [uvst_pkg::POS_W-1:0]   pos_z;
  logic signed [uvst_pkg::NORM_W-1:0]  norm_x;
  logic signed [uvst_pkg::NORM_W-1:0]  norm_y;
  logic signed [uvst_pkg::NORM_W-1:0]  norm_z;
  logic [uvst_pkg::COLOR_W-1:0]        vertex_color;
  logic [uvst_pkg::CORNER_W-1:0]       corner_a;
  logic [uvst_pkg::CORNER_W-1:0]       corner_b;
  logic [uvst_pkg::CORNER_W-1:0]       corner_c;
  logic                                last;

  modport source (
    output valid, kind, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
           vertex_color, corner_a, corner_b, corner_c, last,
    input  ready
  );

  modport sink (
    input  valid, kind, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
           vertex_color, corner_a, corner_b, corner_c, last,
    output ready
  );

endinterface

// File: hw/rtl/uv_sphere_tessellator_unit.sv
// ----------------------------------------------------------------------------
// uv_sphere_tessellator_unit
// UV sphere mesh generator: vertex positions, normals and colour, and the
// triangle index lists of each latitude band.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per beat: func selects a vertex or a triangle
//   request for the grid point (stack_index, sector_index). Out-of-range
//   requests are dropped at the input and give no beat on rsp.
//   rsp carries the records: one vertex record, or one or two triangle
//   records for a band, the final one marked by last.
//   radius and surface_color are written through cfg_we_i / cfg_idx_i /
//   cfg_data_i while no request is in flight.
// Timing:
//   five register stages (input, table lookup, trig products, radius
//   product, rounding and output).
//   one request enters per cycle while rsp takes every record; an
//   inner-band triangle request holds the output register for two beats,
//   so its successor waits in stage 4 until the second beat is taken.
// Reset and stall:
//   reset empties the pipeline and loads radius 256 and white.
//   ready is chained stage by stage, so a stalled rsp fills the empty
//   stages first and then pushes back on req; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module uv_sphere_tessellator_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [uvst_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [uvst_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  uvst_req_if.sink                           req,
  uvst_rsp_if.source                         rsp
);

  localparam int unsigned IW  = uvst_pkg::IDX_W;
  localparam int unsigned CW  = uvst_pkg::CORNER_W;
  localparam int unsigned NW  = uvst_pkg::NORM_W;
  localparam int unsigned PW  = uvst_pkg::POS_W;

  // triangle corner data carried down the pipe
  typedef struct packed {
    logic [CW-1:0] k1;
    logic [CW-1:0] k2;
    logic          upper;
    logic          lower;
  } tri_t;

  // divide by 2^sh, round to nearest with halves away from zero
  function automatic logic signed [PW-1:0] rnd_shift(input logic signed [48:0] v,
                                                     input logic [5:0] sh);
    logic [48:0] mag;
    logic [48:0] res;
    mag = v[48] ? 49'(-v) : 49'(v);
    res = (mag + (49'd1 << (sh - 6'd1))) >> sh;
    return v[48] ? -PW'(res) : PW'(res);
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  logic [uvst_pkg::RADIUS_W-1:0] radius_q;
  logic [uvst_pkg::COLOR_W-1:0]  color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= uvst_pkg::RADIUS_RST;
      color_q  <= uvst_pkg::COLOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        uvst_pkg::CFG_RADIUS: radius_q <= cfg_data_i[uvst_pkg::RADIUS_W-1:0];
        uvst_pkg::CFG_COLOR:  color_q  <= cfg_data_i[uvst_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [uvst_pkg::RADIUS_W:0] radius_s;
  assign radius_s = $signed({1'b0, radius_q});

  // --------------------------------------------------------------------------
  // pipeline registers
  logic          s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q, out_phase_q;
  logic          s1_en, s2_en, s3_en, s4_en, out_en;

  logic          s1_func_q;
  logic [IW-1:0] s1_stk_q;
  logic [IW-1:0] s1_sec_q;

  logic                 s2_func_q;
  logic signed [NW-1:0] s2_ring_q, s2_zc_q, s2_cs_q, s2_sn_q;
  tri_t                 s2_tri_q;

  logic                 s3_func_q;
  logic signed [31:0]   s3_px_q, s3_py_q;
  logic signed [32:0]   s3_pz_q;
  logic signed [NW-1:0] s3_zc_q;
  tri_t                 s3_tri_q;

  logic                 s4_func_q;
  logic signed [48:0]   s4_mx_q, s4_my_q;
  logic signed [NW-1:0] s4_nx_q, s4_ny_q, s4_nz_q;
  logic signed [PW-1:0] s4_pz_q;
  tri_t                 s4_tri_q;

  logic                            out_func_q;
  logic signed [PW-1:0]            out_px_q, out_py_q, out_pz_q;
  logic signed [NW-1:0]            out_nx_q, out_ny_q, out_nz_q;
  logic [uvst_pkg::COLOR_W-1:0]    out_color_q;
  logic [CW-1:0]                   out_k1_q, out_k2_q, out_k1p1_q, out_k2p1_q;
  logic                            out_up_q, out_lo_q;

  logic rsp_last;
  logic req_ok;
  logic req_fire;

  // stage enables chained back from the output
  assign out_en    = !out_v_q || (rsp.ready && rsp_last);
  assign s4_en     = !s4_v_q || out_en;
  assign s3_en     = !s3_v_q || s4_en;
  assign s2_en     = !s2_v_q || s3_en;
  assign s1_en     = !s1_v_q || s2_en;
  assign req.ready = s1_en;

  // range check of the request
  always_comb begin
    if (req.func == uvst_pkg::FUNC_TRIANGLE) begin
      req_ok = (req.stack_index < IW'(uvst_pkg::STACKS)) &&
               (req.sector_index < IW'(uvst_pkg::SECTORS));
    end else begin
      req_ok = (req.stack_index <= IW'(uvst_pkg::STACKS)) &&
               (req.sector_index <= IW'(uvst_pkg::SECTORS));
    end
  end
  assign req_fire = req.valid && s1_en;

  // valid bits and output phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
      out_phase_q <= 1'b0;
    end else begin
      if (s1_en) s1_v_q <= req.valid && req_ok;
      if (s2_en) s2_v_q <= s1_v_q;
      if (s3_en) s3_v_q <= s2_v_q;
      if (s4_en) s4_v_q <= s3_v_q;
      if (out_en) begin
        out_v_q     <= s4_v_q;
        out_phase_q <= 1'b0;
      end else if (rsp.valid && rsp.ready) begin
        out_phase_q <= 1'b1;
      end
    end
  end

  // stage 1: capture accepted in-range request
  always_ff @(posedge clk_i) begin
    if (req_fire && req_ok) begin
      s1_func_q <= req.func;
      s1_stk_q  <= req.stack_index;
      s1_sec_q  <= req.sector_index;
    end
  end

  // stage 2: table lookup and vertex numbering
  logic [CW-1:0] s2_k1;
  assign s2_k1 = CW'(s1_stk_q) * CW'(uvst_pkg::COLS) + CW'(s1_sec_q);

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_v_q) begin
      s2_func_q      <= s1_func_q;
      s2_ring_q      <= uvst_pkg::RING_TBL[s1_stk_q[uvst_pkg::STK_IW-1:0]];
      s2_zc_q        <= uvst_pkg::ZC_TBL[s1_stk_q[uvst_pkg::STK_IW-1:0]];
      s2_cs_q        <= uvst_pkg::CS_TBL[s1_sec_q[uvst_pkg::SEC_IW-1:0]];
      s2_sn_q        <= uvst_pkg::SN_TBL[s1_sec_q[uvst_pkg::SEC_IW-1:0]];
      s2_tri_q.k1    <= s2_k1;
      s2_tri_q.k2    <= s2_k1 + CW'(uvst_pkg::COLS);
      s2_tri_q.upper <= (s1_stk_q != '0);
      s2_tri_q.lower <= (s1_stk_q != IW'(uvst_pkg::STACKS - 1));
    end
  end

  // stage 3: trig products and radius times height
  always_ff @(posedge clk_i) begin
    if (s3_en && s2_v_q) begin
      s3_func_q <= s2_func_q;
      s3_px_q   <= s2_ring_q * s2_cs_q;
      s3_py_q   <= s2_ring_q * s2_sn_q;
      s3_pz_q   <= radius_s * s2_zc_q;
      s3_zc_q   <= s2_zc_q;
      s3_tri_q  <= s2_tri_q;
    end
  end

  // stage 4: radius times ring products, normals and height rounded
  always_ff @(posedge clk_i) begin
    if (s4_en && s3_v_q) begin
      s4_func_q <= s3_func_q;
      s4_mx_q   <= radius_s * s3_px_q;
      s4_my_q   <= radius_s * s3_py_q;
      s4_nx_q   <= NW'(rnd_shift(49'(s3_px_q), 6'd14));
      s4_ny_q   <= NW'(rnd_shift(49'(s3_py_q), 6'd14));
      s4_nz_q   <= s3_zc_q;
      s4_pz_q   <= rnd_shift(49'(s3_pz_q), 6'd14);
      s4_tri_q  <= s3_tri_q;
    end
  end

  // stage 5: positions rounded into the output register
  always_ff @(posedge clk_i) begin
    if (out_en && s4_v_q) begin
      out_func_q  <= s4_func_q;
      out_px_q    <= rnd_shift(s4_mx_q, 6'd28);
      out_py_q    <= rnd_shift(s4_my_q, 6'd28);
      out_pz_q    <= s4_pz_q;
      out_nx_q    <= s4_nx_q;
      out_ny_q    <= s4_ny_q;
      out_nz_q    <= s4_nz_q;
      out_color_q <= color_q;
      out_k1_q    <= s4_tri_q.k1;
      out_k2_q    <= s4_tri_q.k2;
      out_k1p1_q  <= s4_tri_q.k1 + CW'(1);
      out_k2p1_q  <= s4_tri_q.k2 + CW'(1);
      out_up_q    <= s4_tri_q.upper;
      out_lo_q    <= s4_tri_q.lower;
    end
  end

  // record assembly: vertex, or upper then lower triangle
  logic tri_first;
  assign tri_first = out_up_q && !out_phase_q;

  always_comb begin
    rsp.valid        = out_v_q;
    rsp.kind         = out_func_q;
    rsp.pos_x        = '0;
    rsp.pos_y        = '0;
    rsp.pos_z        = '0;
    rsp.norm_x       = '0;
    rsp.norm_y       = '0;
    rsp.norm_z       = '0;
    rsp.vertex_color = '0;
    rsp.corner_a     = '0;
    rsp.corner_b     = '0;
    rsp.corner_c     = '0;
    rsp_last         = 1'b1;
    if (out_func_q == uvst_pkg::FUNC_VERTEX) begin
      rsp.pos_x        = out_px_q;
      rsp.pos_y        = out_py_q;
      rsp.pos_z        = out_pz_q;
      rsp.norm_x       = out_nx_q;
      rsp.norm_y       = out_ny_q;
      rsp.norm_z       = out_nz_q;
      rsp.vertex_color = out_color_q;
    end else if (tri_first) begin
      rsp.corner_a = out_k1_q;
      rsp.corner_b = out_k2_q;
      rsp.corner_c = out_k1p1_q;
      rsp_last     = !out_lo_q;
    end else begin
      rsp.corner_a = out_k1p1_q;
      rsp.corner_b = out_k2_q;
      rsp.corner_c = out_k2p1_q;
    end
    rsp.last = rsp_last;
  end

endmodule
